// ----- rtl/bfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

	// Payload field widths of the request and response channels
	localparam int unsigned REQ_W    = 12;
	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned STATUS_W = 2;

	// Response status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_BADFREE = 2'd2
	} status_t;

	// Command codes
	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} command_t;

endpackage : bfa_pkg
`default_nettype wire

// ----- rtl/bfa_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel: command, allocate size and release offset.
// ----------------------------------------------------------------------------
interface bfa_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [11:0] request_bytes;
	logic [11:0] release_offset;

	modport source (output valid, command, request_bytes, release_offset, input ready);
	modport sink   (input valid, command, request_bytes, release_offset, output ready);
endinterface : bfa_req_if
`default_nettype wire

// ----- rtl/bfa_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Response channel: status and allocated payload offset.
// ----------------------------------------------------------------------------
interface bfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] payload_offset;

	modport source (output valid, status, payload_offset, input ready);
	modport sink   (input valid, status, payload_offset, output ready);
endinterface : bfa_rsp_if
`default_nettype wire

// ----- rtl/bfa_hdr_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_hdr_mem
// Header memory: one write port, one read port, registered read data.
// Entry zero reads as the initial whole-pool header until first written.
// ----------------------------------------------------------------------------
module bfa_hdr_mem #(
	parameter int unsigned AW = 12,
	parameter int unsigned HW = 13,
	parameter logic signed [HW-1:0] INIT0 = '0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  we,
	input  wire [AW-1:0]         waddr,
	input  wire signed [HW-1:0]  wdata,
	input  wire                  re,
	input  wire [AW-1:0]         raddr,
	output logic signed [HW-1:0] rdata
);

	logic signed [HW-1:0] mem [2**AW];
	logic signed [HW-1:0] rd_s1;
	logic                 rd_zero_s1;
	logic                 zero_written_q;

	// Storage array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_s1 <= mem[raddr];
		end
	end

	// Entry zero override until its first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_written_q <= 1'b0;
			rd_zero_s1     <= 1'b0;
		end else begin
			if (we && waddr == '0) begin
				zero_written_q <= 1'b1;
			end
			if (re) begin
				rd_zero_s1 <= (raddr == '0) && !zero_written_q;
			end
		end
	end

	assign rdata = rd_zero_s1 ? INIT0 : rd_s1;

endmodule : bfa_hdr_mem
`default_nettype wire

// ----- rtl/best_fit_block_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit
// Best-fit allocator over an implicit block list kept in a header memory.
//
//  channel  dir  payload                                   transfer
//  req_ch   in   command, request_bytes, release_offset    valid & ready
//  rsp_ch   out  status, payload_offset                    valid & ready
//
// One request at a time. The list walk reads one header per cycle from the
// header memory. An allocate walks the whole list; a free walks up to the
// target block, then merges it with a free next block (unless the freed
// block ends the pool) and a free previous block. A rejected free stops at
// the block where it fails; a zero-size allocate or a low offset skips the walk.
// After reset the pool is one free block; no clearing pass is needed.
// A held response stalls the next request only at completion.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_unit
	import bfa_pkg::*;
#(
	parameter int unsigned POOL_BYTES   = 4096,
	parameter int unsigned HEADER_BYTES = 4
) (
	input wire      clk,
	input wire      arst_n,
	bfa_req_if.sink   req_ch,
	bfa_rsp_if.source rsp_ch
);

	localparam int unsigned AW = $clog2(POOL_BYTES);
	localparam int unsigned HW = AW + 1;
	localparam int unsigned PW = AW + 2;
	localparam int unsigned EW = ((HW > REQ_W) ? HW : REQ_W) + 2;
	localparam logic signed [HW-1:0] INIT0 = HW'(POOL_BYTES - HEADER_BYTES);
	localparam logic [PW-1:0] POOL_P = PW'(POOL_BYTES);
	localparam logic [PW-1:0] HDR_P  = PW'(HEADER_BYTES);

	typedef enum logic [2:0] {
		S_IDLE, S_AW, S_AS, S_FW, S_FN, S_FP, S_DONE
	} state_t;

	state_t               state_q;
	logic [PW-1:0]        pos_q;
	logic [REQ_W-1:0]     req_q;
	logic [OFFSET_W-1:0]  tgt_q;
	logic                 found_q;
	logic [AW-1:0]        best_q;
	logic signed [HW-1:0] bleft_q;
	logic [AW-1:0]        prev_q;
	logic signed [HW-1:0] prev_hdr_q;
	logic                 has_prev_q;
	logic signed [HW-1:0] fsize_q;
	status_t              res_status_q;
	logic [OFFSET_W-1:0]  res_off_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [OFFSET_W-1:0]  out_off_q;

	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic signed [HW-1:0] mem_wdata, hdr;

	logic [HW-1:0]        hdr_mag;
	logic [PW-1:0]        nxt;
	logic                 nxt_in;
	logic signed [EW-1:0] left_e;
	logic                 take;
	logic                 found_n;
	logic [AW-1:0]        best_n;
	logic signed [HW-1:0] bleft_n;
	logic [EW-1:0]        pos_e, tgt_e;
	logic signed [HW-1:0] merged;
	logic [PW-1:0]        rem;

	bfa_hdr_mem #(.AW(AW), .HW(HW), .INIT0(INIT0)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (hdr)
	);

	// Walk arithmetic on the header just read
	always_comb begin
		hdr_mag = (hdr < 0) ? HW'(-hdr) : HW'(hdr);
		nxt     = pos_q + HDR_P + PW'(hdr_mag);
		nxt_in  = nxt < POOL_P;
		left_e  = EW'(hdr) - $signed(EW'(req_q)) - $signed(EW'(HEADER_BYTES));
		take    = (hdr > 0) && (left_e > 0) && (!found_q || left_e < EW'(bleft_q));
		found_n = found_q || take;
		best_n  = take ? pos_q[AW-1:0] : best_q;
		bleft_n = take ? HW'(left_e) : bleft_q;
		pos_e   = EW'(pos_q);
		tgt_e   = EW'(tgt_q);
		merged  = fsize_q + ((hdr > 0) ? (hdr + HW'(HEADER_BYTES)) : '0);
		rem     = PW'(best_q) + HDR_P + PW'(req_q);
	end

	// Memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_re = req_ch.valid;
			end
			S_AW: begin
				mem_re    = nxt_in;
				mem_raddr = nxt[AW-1:0];
				mem_we    = !nxt_in && found_n;
				mem_waddr = best_n;
				mem_wdata = -HW'(req_q);
			end
			S_AS: begin
				mem_we    = 1'b1;
				mem_waddr = rem[AW-1:0];
				mem_wdata = bleft_q;
			end
			S_FW: begin
				mem_re    = nxt_in;
				mem_raddr = nxt[AW-1:0];
				mem_we    = (pos_e == tgt_e) && (hdr < 0) && !nxt_in;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = HW'(hdr_mag);
			end
			S_FN: begin
				mem_we    = 1'b1;
				mem_waddr = tgt_q[AW-1:0];
				mem_wdata = merged;
			end
			S_FP: begin
				mem_we    = has_prev_q && (prev_hdr_q > 0);
				mem_waddr = prev_q;
				mem_wdata = prev_hdr_q + fsize_q + HW'(HEADER_BYTES);
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pos_q        <= '0;
			req_q        <= '0;
			tgt_q        <= '0;
			found_q      <= 1'b0;
			best_q       <= '0;
			bleft_q      <= '0;
			prev_q       <= '0;
			prev_hdr_q   <= '0;
			has_prev_q   <= 1'b0;
			fsize_q      <= '0;
			res_status_q <= ST_OK;
			res_off_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_off_q    <= '0;
		end else begin
			// Response drained; a completing request reloads it below
			if (out_valid_q && rsp_ch.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_ch.valid) begin
						pos_q      <= '0;
						found_q    <= 1'b0;
						has_prev_q <= 1'b0;
						req_q      <= req_ch.request_bytes;
						res_off_q  <= '0;
						if (req_ch.command == CMD_ALLOC) begin
							tgt_q <= '0;
							if (req_ch.request_bytes == '0) begin
								res_status_q <= ST_NOFIT;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_AW;
							end
						end else begin
							tgt_q <= req_ch.release_offset - OFFSET_W'(HEADER_BYTES);
							if (req_ch.release_offset < OFFSET_W'(HEADER_BYTES)) begin
								res_status_q <= ST_BADFREE;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_FW;
							end
						end
					end
				end
				S_AW: begin
					found_q <= found_n;
					best_q  <= best_n;
					bleft_q <= bleft_n;
					pos_q   <= nxt;
					if (!nxt_in) begin
						if (found_n) begin
							state_q <= S_AS;
						end else begin
							res_status_q <= ST_NOFIT;
							state_q      <= S_DONE;
						end
					end
				end
				S_AS: begin
					res_status_q <= ST_OK;
					res_off_q    <= OFFSET_W'(PW'(best_q) + HDR_P);
					state_q      <= S_DONE;
				end
				S_FW: begin
					if (pos_e == tgt_e) begin
						if (hdr < 0) begin
							fsize_q <= HW'(hdr_mag);
							state_q <= nxt_in ? S_FN : S_FP;
						end else begin
							res_status_q <= ST_BADFREE;
							state_q      <= S_DONE;
						end
					end else if (pos_e > tgt_e || !nxt_in) begin
						res_status_q <= ST_BADFREE;
						state_q      <= S_DONE;
					end else begin
						prev_q     <= pos_q[AW-1:0];
						prev_hdr_q <= hdr;
						has_prev_q <= 1'b1;
						pos_q      <= nxt;
					end
				end
				S_FN: begin
					fsize_q <= merged;
					state_q <= S_FP;
				end
				S_FP: begin
					res_status_q <= ST_OK;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp_ch.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_off_q    <= res_off_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ch.ready          = (state_q == S_IDLE);
	assign rsp_ch.valid          = out_valid_q;
	assign rsp_ch.status         = out_status_q;
	assign rsp_ch.payload_offset = out_off_q;

	// Failed requests never carry an offset
	a_fail_zero_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_OK |-> out_off_q == '0)
		else $error("failed response with nonzero offset");

	// One request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_ch.valid && req_ch.ready |=> !req_ch.ready)
		else $error("request accepted while busy");

	// Walk position stays inside the pool
	a_walk_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_AW || state_q == S_FW |-> pos_q < POOL_P)
		else $error("walk position beyond pool");

endmodule : best_fit_block_allocator_unit
`default_nettype wire
